FILE: rtl/triangle_coverage_depth_unit_defines.svh
// Assertion helpers used by the RTL.
`ifndef TRIANGLE_COVERAGE_DEPTH_UNIT_DEFINES_SVH
`define TRIANGLE_COVERAGE_DEPTH_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TCD_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");

`endif

FILE: rtl/tcd_pkg.sv
package tcd_pkg;

    // Width of a vertex depth and of the reported depth.
    localparam int DEPTH_BITS = 24;

    typedef struct packed {
        logic [11:0]           pixel_x;
        logic [11:0]           pixel_y;
        logic signed [15:0]    v0_x;
        logic signed [15:0]    v0_y;
        logic [DEPTH_BITS-1:0] v0_z;
        logic signed [15:0]    v1_x;
        logic signed [15:0]    v1_y;
        logic [DEPTH_BITS-1:0] v1_z;
        logic signed [15:0]    v2_x;
        logic signed [15:0]    v2_y;
        logic [DEPTH_BITS-1:0] v2_z;
    } t_in;

    typedef struct packed {
        logic                  inside_res;
        logic [DEPTH_BITS-1:0] depth;
        logic                  degenerate;
    } t_out;

endpackage

FILE: rtl/triangle_coverage_depth_unit.sv
// Pipeline: each accepted word passes through the numbered stages, the divider row and the output register.
// Throughput: one word per cycle while the output is not stalled; the divider is a row of restoring stages,
// one quotient bit per stage, so nothing in the pipe is shared between words.
// Reset: i_rst_n is synchronous and active low; it clears every stage valid bit.
// All stages advance together whenever the output register is empty or taken.
`include "triangle_coverage_depth_unit_defines.svh"

module triangle_coverage_depth_unit #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tcd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output tcd_pkg::t_out o_data
);
    import tcd_pkg::*;

    // Pixel scaled into the vertex fixed-point grid.
    localparam int PXW  = 12 + COORD_FRAC_BITS;
    // Signed width of pixel minus vertex.
    localparam int DXW  = ((PXW > 16) ? PXW : 16) + 2;
    // Signed width of a vertex difference.
    localparam int VDW  = 17;
    localparam int PRW  = VDW + DXW;
    // Width of the barycentric numerators and the denominator.
    localparam int NW   = PRW + 1;
    localparam int GW   = NW + 2;
    localparam int DZW  = DEPTH_BITS + 1;
    localparam int NUMW = NW + DZW + 1;
    // Quotient bits kept; anything larger saturates the depth anyway.
    localparam int Q    = DEPTH_BITS + 2;
    localparam int ZSW  = Q + 2;

    typedef struct packed {
        logic                  cov;
        logic                  degen;
        logic [DEPTH_BITS-1:0] z2;
    } t_side;

    // The whole pipe moves as one; the last register is the output register.
    logic en;
    logic r_ov;
    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_ov;

    // Stage 1: coordinate and depth differences.
    logic [PXW-1:0] px_u, py_u;
    assign px_u = PXW'(i_data.pixel_x) << COORD_FRAC_BITS;
    assign py_u = PXW'(i_data.pixel_y) << COORD_FRAC_BITS;

    logic                         r_v1;
    logic signed [DXW-1:0]        r_dx, r_dy;
    logic signed [VDW-1:0]        r_a, r_b, r_c, r_e, r_f;
    logic signed [DZW-1:0]        r_dz0, r_dz1;
    logic [DEPTH_BITS-1:0]        r_z2_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_dx   <= DXW'($signed({1'b0, px_u})) - DXW'(i_data.v2_x);
            r_dy   <= DXW'($signed({1'b0, py_u})) - DXW'(i_data.v2_y);
            r_a    <= VDW'(i_data.v1_y) - VDW'(i_data.v2_y);
            r_b    <= VDW'(i_data.v2_x) - VDW'(i_data.v1_x);
            r_c    <= VDW'(i_data.v2_y) - VDW'(i_data.v0_y);
            r_e    <= VDW'(i_data.v0_x) - VDW'(i_data.v2_x);
            r_f    <= VDW'(i_data.v0_y) - VDW'(i_data.v2_y);
            r_dz0  <= $signed({1'b0, DEPTH_BITS'(i_data.v0_z)})
                      - $signed({1'b0, DEPTH_BITS'(i_data.v2_z)});
            r_dz1  <= $signed({1'b0, DEPTH_BITS'(i_data.v1_z)})
                      - $signed({1'b0, DEPTH_BITS'(i_data.v2_z)});
            r_z2_1 <= DEPTH_BITS'(i_data.v2_z);
        end
    end

    // Stage 2: the edge products p0a, p0b, p1a, p1b, pda and pdb.
    logic                  r_v2;
    logic signed [PRW-1:0] r_p0a, r_p0b, r_p1a, r_p1b, r_pda, r_pdb;
    logic signed [DZW-1:0] r_dz0_2, r_dz1_2;
    logic [DEPTH_BITS-1:0] r_z2_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_p0a   <= PRW'(r_a) * PRW'(r_dx);
            r_p0b   <= PRW'(r_b) * PRW'(r_dy);
            r_p1a   <= PRW'(r_c) * PRW'(r_dx);
            r_p1b   <= PRW'(r_e) * PRW'(r_dy);
            r_pda   <= PRW'(r_a) * PRW'(r_e);
            r_pdb   <= PRW'(r_b) * PRW'(r_f);
            r_dz0_2 <= r_dz0;
            r_dz1_2 <= r_dz1;
            r_z2_2  <= r_z2_1;
        end
    end

    // Stage 3: numerators n0, n1 and denominator d.
    logic                  r_v3;
    logic signed [NW-1:0]  r_n0, r_n1, r_d;
    logic signed [DZW-1:0] r_dz0_3, r_dz1_3;
    logic [DEPTH_BITS-1:0] r_z2_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r_n0    <= NW'(r_p0a) + NW'(r_p0b);
            r_n1    <= NW'(r_p1a) + NW'(r_p1b);
            r_d     <= NW'(r_pda) + NW'(r_pdb);
            r_dz0_3 <= r_dz0_2;
            r_dz1_3 <= r_dz1_2;
            r_z2_3  <= r_z2_2;
        end
    end

    // Stage 4: coverage by sign tests, and the depth products m0 and m1.
    logic signed [GW-1:0] g;
    logic                 cov_pos, cov_neg;
    assign g       = GW'(r_d) - GW'(r_n0) - GW'(r_n1);
    assign cov_pos = (r_n0 > 0) && (r_n1 > 0) && (g > 0);
    assign cov_neg = (r_n0 < 0) && (r_n1 < 0) && (g < 0);

    logic                   r_v4;
    logic signed [NUMW-1:0] r_m0, r_m1;
    logic signed [NW-1:0]   r_d4;
    t_side                  r_sd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_m0        <= NUMW'(r_n0) * NUMW'(r_dz0_3);
            r_m1        <= NUMW'(r_n1) * NUMW'(r_dz1_3);
            r_d4        <= r_d;
            r_sd4.degen <= (r_d == '0);
            r_sd4.cov   <= r_d[NW-1] ? cov_neg : cov_pos;
            r_sd4.z2    <= r_z2_3;
        end
    end

    // Stage 5: full numerator.
    logic                   r_v5;
    logic signed [NUMW-1:0] r_num;
    logic signed [NW-1:0]   r_d5;
    t_side                  r_sd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= r_v4;
        end
        if (en) begin
            r_num <= r_m0 + r_m1;
            r_d5  <= r_d4;
            r_sd5 <= r_sd4;
        end
    end

    // Stage 6: magnitudes and quotient sign.
    logic                r_v6;
    logic [NUMW-1:0]     r_mag;
    logic [NW-1:0]       r_dm6;
    logic                r_qneg6;
    t_side               r_sd6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_v5;
        end
        if (en) begin
            r_mag   <= r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);
            r_dm6   <= r_d5[NW-1] ? NW'(-r_d5) : NW'(r_d5);
            r_qneg6 <= r_num[NUMW-1] ^ r_d5[NW-1];
            r_sd6   <= r_sd5;
        end
    end

    // Stage 7: saturation check, then the divider row. A quotient of 2^Q or
    // more already clamps the depth, and a zero divisor also lands here.
    logic [NUMW-1:0] mag_hi;
    assign mag_hi = r_mag >> Q;

    logic          r_dv  [0:Q];
    logic [NW:0]   r_rem [0:Q];
    logic [Q-1:0]  r_low [0:Q];
    logic [Q-1:0]  r_q   [0:Q];
    logic [NW-1:0] r_dm  [0:Q];
    logic          r_ovf [0:Q];
    logic          r_qneg[0:Q];
    t_side         r_sd  [0:Q];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v6;
        end
        if (en) begin
            r_ovf[0]  <= (mag_hi >= NUMW'(r_dm6));
            r_rem[0]  <= (NW + 1)'(mag_hi);
            r_low[0]  <= r_mag[Q-1:0];
            r_q[0]    <= '0;
            r_dm[0]   <= r_dm6;
            r_qneg[0] <= r_qneg6;
            r_sd[0]   <= r_sd6;
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_div
        logic [NW:0] trial;
        logic        fits;
        assign trial = {r_rem[k][NW-1:0], r_low[k][Q-1]};
        assign fits  = (trial >= {1'b0, r_dm[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_rem[k+1]  <= fits ? (trial - {1'b0, r_dm[k]}) : trial;
                r_low[k+1]  <= r_low[k] << 1;
                r_q[k+1]    <= {r_q[k][Q-2:0], fits};
                r_dm[k+1]   <= r_dm[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_qneg[k+1] <= r_qneg[k];
                r_sd[k+1]   <= r_sd[k];
            end
        end
    end

    // Final stage: signed add to z2, clamp, degenerate override.
    localparam logic [DEPTH_BITS-1:0] ZMAX = '1;
    logic [Q-1:0]          qmag;
    logic signed [ZSW-1:0] zsum;
    logic [DEPTH_BITS-1:0] zclamp;
    assign qmag = r_ovf[Q] ? '1 : r_q[Q];
    assign zsum = r_qneg[Q]
                ? $signed(ZSW'(r_sd[Q].z2)) - $signed(ZSW'(qmag))
                : $signed(ZSW'(r_sd[Q].z2)) + $signed(ZSW'(qmag));

    always_comb begin
        priority if (zsum < 0) begin
            zclamp = '0;
        end else if (zsum > $signed(ZSW'(ZMAX))) begin
            zclamp = ZMAX;
        end else begin
            zclamp = DEPTH_BITS'(zsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[Q];
        end
        if (en) begin
            o_data.degenerate <= r_sd[Q].degen;
            o_data.inside_res <= r_sd[Q].cov && !r_sd[Q].degen;
            o_data.depth      <= r_sd[Q].degen ? '0 : zclamp;
        end
    end

    // A degenerate triangle never reports coverage or depth.
    `TCD_ASSERT_IMPLIES(a_degen_zero, i_clk, i_rst_n, o_valid && o_data.degenerate, !o_data.inside_res && (o_data.depth == '0))
    // The pipe only pushes back while a result sits unclaimed at the output.
    `TCD_ASSERT_IMPLIES(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // A stalled output word is still offered in the next cycle.
    `TCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule
